// ===== rtl/tcpfin_pkg.sv =====
// Shared constants, types and ones complement helpers for the FIN+ACK reply header builder.
package tcpfin_pkg;

	localparam int unsigned MAX_FRAME   = 1514;
	localparam int unsigned ETH_LEN     = 14;
	localparam int unsigned HDRS_LEN    = 40;
	localparam int unsigned TCP_HDR_LEN = 20;

	// largest payload byte count that still fits in MAX_FRAME
	localparam logic [15:0] CNT_LIMIT = 16'(MAX_FRAME - ETH_LEN - HDRS_LEN);

	localparam logic [15:0] IP_VER_IHL   = 16'h4500;
	localparam logic [15:0] IP_ID        = 16'd242;
	localparam logic [7:0]  IP_TTL       = 8'd111;
	localparam logic [7:0]  PROTO_TCP    = 8'd6;
	localparam logic [3:0]  TCP_DATA_OFF = 4'(TCP_HDR_LEN / 4);
	localparam logic [7:0]  FLAG_FIN_ACK = 8'h11;
	localparam int unsigned FLAG_PSH_POS = 3;

	localparam logic REQ_HEADER  = 1'b0;
	localparam logic REQ_PAYLOAD = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOT_TCP = 2'd1,
		ST_TOO_BIG = 2'd2
	} status_t;

	// snapshot taken when the last payload byte arrives
	typedef struct packed {
		status_t     status;
		logic [15:0] count;
		logic [15:0] psum;
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [31:0] seq;
		logic [31:0] ack;
		logic        push;
	} snap_t;

	// partial checksum totals
	typedef struct packed {
		status_t     status;
		logic [15:0] tot;
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [7:0]  flags;
		logic [18:0] ip_raw;
		logic [19:0] tcp_a;
		logic [19:0] tcp_b;
	} part_t;

	// end-around carry add of two 16-bit words
	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + 16'(s[16]);
	endfunction

	// fold a 20-bit integer total to a 16-bit ones complement sum
	function automatic logic [15:0] fold20(input logic [19:0] x);
		logic [16:0] t;
		t = {1'b0, x[15:0]} + 17'(x[19:16]);
		return t[15:0] + 16'(t[16]);
	endfunction

endpackage

// ===== rtl/tcpfin_if.sv =====
// Valid/ready channel interfaces for ingress beats and reply results.
interface tcpfin_in_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [31:0] ingress_src_ip;
	logic [31:0] ingress_dst_ip;
	logic [15:0] ingress_src_port;
	logic [15:0] ingress_dst_port;
	logic [31:0] ingress_seq;
	logic [31:0] ingress_ack;
	logic        ingress_push;
	logic [15:0] ingress_payload_len;
	logic [7:0]  ingress_protocol;
	logic [7:0]  payload_byte;
	logic        last_byte;

	modport source (
		output valid, req_type, ingress_src_ip, ingress_dst_ip, ingress_src_port,
			ingress_dst_port, ingress_seq, ingress_ack, ingress_push,
			ingress_payload_len, ingress_protocol, payload_byte, last_byte,
		input  ready
	);
	modport sink (
		input  valid, req_type, ingress_src_ip, ingress_dst_ip, ingress_src_port,
			ingress_dst_port, ingress_seq, ingress_ack, ingress_push,
			ingress_payload_len, ingress_protocol, payload_byte, last_byte,
		output ready
	);
endinterface

interface tcpfin_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] ip_total_len;
	logic [15:0] ip_checksum;
	logic [31:0] reply_src_ip;
	logic [31:0] reply_dst_ip;
	logic [15:0] reply_src_port;
	logic [15:0] reply_dst_port;
	logic [31:0] reply_seq;
	logic [31:0] reply_ack;
	logic [7:0]  tcp_flags;
	logic [15:0] tcp_checksum;

	modport source (
		output valid, status, ip_total_len, ip_checksum, reply_src_ip, reply_dst_ip,
			reply_src_port, reply_dst_port, reply_seq, reply_ack, tcp_flags,
			tcp_checksum,
		input  ready
	);
	modport sink (
		input  valid, status, ip_total_len, ip_checksum, reply_src_ip, reply_dst_ip,
			reply_src_port, reply_dst_port, reply_seq, reply_ack, tcp_flags,
			tcp_checksum,
		output ready
	);
endinterface

// ===== rtl/tcpfin_accum.sv =====
// Header latch, payload word accumulator and end-of-packet snapshot register.
module tcpfin_accum import tcpfin_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tcpfin_in_if.sink   seg,
	input  logic        snap_take,
	output logic        snap_valid,
	output snap_t       snap
);

	logic [31:0] src_ip_q, dst_ip_q, seq_q, ack_q;
	logic [15:0] src_port_q, dst_port_q, len_q;
	logic        push_q, not_tcp_q;
	logic [15:0] payload_sum_q, byte_count_q;
	logic [7:0]  odd_q;

	logic        v_s1;
	snap_t       snap_s1;
	snap_t       snap_next;

	logic        accept, hdr_beat, byte_beat, last_beat, even;
	logic [15:0] cnt_inc, word, sum_next;

	assign seg.ready = !v_s1 || snap_take;
	assign accept    = seg.valid && seg.ready;
	assign hdr_beat  = accept && (seg.req_type == REQ_HEADER);
	assign byte_beat = accept && (seg.req_type == REQ_PAYLOAD);
	assign last_beat = byte_beat && seg.last_byte;

	assign even    = !byte_count_q[0];
	assign cnt_inc = (byte_count_q == 16'hFFFF) ? byte_count_q : byte_count_q + 16'd1;
	// even count: this byte opens a word (zero-padded if it is the last one)
	assign word     = even ? {seg.payload_byte, 8'h00} : {odd_q, seg.payload_byte};
	assign sum_next = ones_add(payload_sum_q, word);

	always_comb begin
		snap_next.count = cnt_inc;
		snap_next.psum  = sum_next;
		snap_next.sip   = dst_ip_q;
		snap_next.dip   = src_ip_q;
		snap_next.sport = dst_port_q;
		snap_next.dport = src_port_q;
		snap_next.seq   = ack_q;
		snap_next.ack   = seq_q + {16'h0000, len_q};
		snap_next.push  = push_q;
		priority if (not_tcp_q) begin
			snap_next.status = ST_NOT_TCP;
		end else if (cnt_inc > CNT_LIMIT) begin
			snap_next.status = ST_TOO_BIG;
		end else begin
			snap_next.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_ip_q      <= '0;
			dst_ip_q      <= '0;
			seq_q         <= '0;
			ack_q         <= '0;
			src_port_q    <= '0;
			dst_port_q    <= '0;
			len_q         <= '0;
			push_q        <= 1'b0;
			not_tcp_q     <= 1'b0;
			payload_sum_q <= '0;
			byte_count_q  <= '0;
			odd_q         <= '0;
		end else if (hdr_beat) begin
			src_ip_q      <= seg.ingress_src_ip;
			dst_ip_q      <= seg.ingress_dst_ip;
			seq_q         <= seg.ingress_seq;
			ack_q         <= seg.ingress_ack;
			src_port_q    <= seg.ingress_src_port;
			dst_port_q    <= seg.ingress_dst_port;
			len_q         <= seg.ingress_payload_len;
			push_q        <= seg.ingress_push;
			not_tcp_q     <= (seg.ingress_protocol != PROTO_TCP);
			payload_sum_q <= '0;
			byte_count_q  <= '0;
			odd_q         <= '0;
		end else if (last_beat) begin
			payload_sum_q <= '0;
			byte_count_q  <= '0;
			odd_q         <= '0;
		end else if (byte_beat) begin
			byte_count_q <= cnt_inc;
			if (even) begin
				odd_q <= seg.payload_byte;
			end else begin
				payload_sum_q <= sum_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= last_beat || (v_s1 && !snap_take);
		end
	end

	always_ff @(posedge clk) begin
		if (last_beat) begin
			snap_s1 <= snap_next;
		end
	end

	assign snap_valid = v_s1;
	assign snap       = snap_s1;

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		last_beat |=> (byte_count_q == 16'h0000) && snap_valid)
		else $error("last byte did not clear the count or load the snapshot");

	a_hdr_clears: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_beat |=> (byte_count_q == 16'h0000) && (payload_sum_q == 16'h0000))
		else $error("header beat did not clear the payload accumulators");

endmodule

// ===== rtl/tcpfin_csum.sv =====
// Two-stage checksum finish: partial totals, then fold, complement and output register.
module tcpfin_csum import tcpfin_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        snap_valid,
	input  snap_t       snap,
	output logic        snap_take,
	tcpfin_out_if.source reply
);

	logic        v_s2, v_q;
	part_t       part_s2, part_next;
	logic        load2, load3;
	logic [15:0] tot, tcp_len;
	logic [7:0]  flags;
	logic [19:0] tcp_raw;
	logic        ok;

	logic [1:0]  status_q;
	logic [15:0] tot_q, ip_ck_q, tcp_ck_q, sport_q, dport_q;
	logic [31:0] sip_q, dip_q, seq_q, ack_q;
	logic [7:0]  flags_q;

	assign load3     = v_s2 && (!v_q || reply.ready);
	assign load2     = snap_valid && (!v_s2 || load3);
	assign snap_take = load2;

	assign tot     = 16'(HDRS_LEN) + snap.count;
	assign tcp_len = 16'(TCP_HDR_LEN) + snap.count;
	assign flags   = FLAG_FIN_ACK | (8'(snap.push) << FLAG_PSH_POS);

	always_comb begin
		part_next.status = snap.status;
		part_next.tot    = tot;
		part_next.sip    = snap.sip;
		part_next.dip    = snap.dip;
		part_next.sport  = snap.sport;
		part_next.dport  = snap.dport;
		part_next.seq    = snap.seq;
		part_next.ack    = snap.ack;
		part_next.flags  = flags;
		part_next.ip_raw = 19'(IP_VER_IHL) + 19'(tot) + 19'(IP_ID) + 19'({IP_TTL, PROTO_TCP})
			+ 19'(snap.sip[31:16]) + 19'(snap.sip[15:0])
			+ 19'(snap.dip[31:16]) + 19'(snap.dip[15:0]);
		part_next.tcp_a  = 20'(snap.psum) + 20'(snap.sip[31:16]) + 20'(snap.sip[15:0])
			+ 20'(snap.dip[31:16]) + 20'(snap.dip[15:0]) + 20'(PROTO_TCP) + 20'(tcp_len);
		part_next.tcp_b  = 20'(snap.sport) + 20'(snap.dport)
			+ 20'(snap.seq[31:16]) + 20'(snap.seq[15:0])
			+ 20'(snap.ack[31:16]) + 20'(snap.ack[15:0])
			+ 20'({TCP_DATA_OFF, 4'h0, flags});
	end

	assign tcp_raw = part_s2.tcp_a + part_s2.tcp_b;
	assign ok      = (part_s2.status == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			v_s2 <= load2 || (v_s2 && !load3);
			v_q  <= load3 || (v_q && !reply.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (load2) begin
			part_s2 <= part_next;
		end
	end

	// a rejected frame carries its status and zero everywhere else
	always_ff @(posedge clk) begin
		if (load3) begin
			status_q <= part_s2.status;
			tot_q    <= ok ? part_s2.tot : '0;
			ip_ck_q  <= ok ? ~fold20({1'b0, part_s2.ip_raw}) : '0;
			tcp_ck_q <= ok ? ~fold20(tcp_raw) : '0;
			sip_q    <= ok ? part_s2.sip : '0;
			dip_q    <= ok ? part_s2.dip : '0;
			sport_q  <= ok ? part_s2.sport : '0;
			dport_q  <= ok ? part_s2.dport : '0;
			seq_q    <= ok ? part_s2.seq : '0;
			ack_q    <= ok ? part_s2.ack : '0;
			flags_q  <= ok ? part_s2.flags : '0;
		end
	end

	assign reply.valid          = v_q;
	assign reply.status         = status_q;
	assign reply.ip_total_len   = tot_q;
	assign reply.ip_checksum    = ip_ck_q;
	assign reply.reply_src_ip   = sip_q;
	assign reply.reply_dst_ip   = dip_q;
	assign reply.reply_src_port = sport_q;
	assign reply.reply_dst_port = dport_q;
	assign reply.reply_seq      = seq_q;
	assign reply.reply_ack      = ack_q;
	assign reply.tcp_flags      = flags_q;
	assign reply.tcp_checksum   = tcp_ck_q;

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !load3 |=> v_s2)
		else $error("partial stage dropped a beat while stalled");

	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		reply.valid && (reply.status == ST_OK) |->
			(reply.ip_total_len <= 16'(MAX_FRAME - ETH_LEN)))
		else $error("ok result with a frame over the size limit");

	a_ok_flags: assert property (@(posedge clk) disable iff (!arst_n)
		reply.valid && (reply.status == ST_OK) |-> reply.tcp_flags[0] && reply.tcp_flags[4])
		else $error("ok result without FIN and ACK");

endmodule

// ===== rtl/tcp_fin_reply_header_builder.sv =====
// The accepted last byte loads the snapshot, then the partial totals, then the output register.
// Throughput: one beat per cycle, header or payload; results stall only the three-deep
// result path (snapshot, partial totals, output register), so input keeps flowing until full.
// Reset (arst_n low) clears the held header, payload sum, byte count and all stage valids.
module tcp_fin_reply_header_builder import tcpfin_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	tcpfin_in_if.sink     seg,
	tcpfin_out_if.source  reply
);

	// snapshot handoff from the accumulator to the checksum finish
	logic  snap_valid;
	logic  snap_take;
	snap_t snap;

	// Accumulator: latches the ingress header on a header beat, pairs payload bytes
	// into big-endian words and sums them; on the last byte it pads an odd tail,
	// decides the status and registers a snapshot for the finish stages.
	tcpfin_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.seg        (seg),
		.snap_take  (snap_take),
		.snap_valid (snap_valid),
		.snap       (snap)
	);

	// Finish: one stage of partial integer totals for both checksums, then the
	// fold, complement and the output register that holds the result beat.
	tcpfin_csum u_csum (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap       (snap),
		.snap_take  (snap_take),
		.reply      (reply)
	);

endmodule
